// ===== hw/rtl/dpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Dead pixel correction package
// Shared constants: defaults, field widths, register indexes and counter codes.
// ----------------------------------------------------------------------------
package dpc_pkg;

   // Default dimensions of the stores and the number of channels per pixel.
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int CHANNELS_DEF   = 3;

   // Channel ports present on the interface (blue, green, red).
   localparam int PORT_CH = 3;

   // Fixed field widths.
   localparam int PIX_W     = 8;
   localparam int DIM_CFG_W = 11;
   localparam int CSR_IDX_W = 1;

   // Window geometry and mean of eight neighbours.
   localparam int WIN        = 3;
   localparam int MEAN_SHIFT = 3;
   localparam int SUM_W      = PIX_W + MEAN_SHIFT;

   // Smallest legal frame dimension and the reset dimensions.
   localparam int MIN_DIM      = 3;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   // Number of input rows begun in the current frame (saturating).
   localparam logic [1:0] ROWS_NONE = 2'd0;
   localparam logic [1:0] ROWS_ONE  = 2'd1;
   localparam logic [1:0] ROWS_FULL = 2'd2;

endpackage

// ===== hw/rtl/dead_pixel_correction.sv =====
// ----------------------------------------------------------------------------
// Dead pixel correction
// Streams raster pixels through two row stores and a 3x3 window and replaces
// flagged interior pixels by the truncated mean of their eight neighbours.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter in raster order on the req_ channel, one transfer when
// req_valid is high and req_stall is low. Each carries a dead flag; a flush
// transfer carries no pixel and serves only to push the tail of a frame out.
// A flush while no frame is in progress is taken and ignored.
// Results leave on the rsp_ channel, one transfer when rsp_valid is high and
// rsp_stall is low. The first frame_width+1 pixels of a frame give no result;
// from then on each input gives the pixel one row and one column behind it,
// and the final pixel of the frame is marked with rsp_out_last.
// The block takes one pixel in every cycle unless req_stall is high. A result
// is registered first in stage 1, with the row store read, and then in the
// output register, with the window update and the mean. While the receiver
// stalls, the held result stays put and the block keeps accepting input
// until an item that has a result of its own would need the output register.
// The csr_ channel is always ready; frame_width and frame_height are clamped
// to 3..MAX_WIDTH and 3..MAX_HEIGHT as they are written. A synchronous
// reset restores 640 x 480 and empties the pipeline; row stores are not
// cleared, as every location is written before it is used.
// ----------------------------------------------------------------------------
module dead_pixel_correction #(
   parameter int MAX_WIDTH  = dpc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dpc_pkg::MAX_HEIGHT_DEF,
   parameter int CHANNELS   = dpc_pkg::CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_flush,
   input  logic                                req_is_dead,
   input  logic [dpc_pkg::PIX_W-1:0]           req_chan_b,
   input  logic [dpc_pkg::PIX_W-1:0]           req_chan_g,
   input  logic [dpc_pkg::PIX_W-1:0]           req_chan_r,
   // corrected output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dpc_pkg::PIX_W-1:0]           rsp_out_b,
   output logic [dpc_pkg::PIX_W-1:0]           rsp_out_g,
   output logic [dpc_pkg::PIX_W-1:0]           rsp_out_r,
   output logic                                rsp_out_last,
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dpc_pkg::DIM_CFG_W-1:0]       csr_wdata
);

   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int WD_W     = COL_W + 1;
   localparam int HT_W     = ROW_W + 1;
   localparam int PIX_BITS = CHANNELS * dpc_pkg::PIX_W + 1;
   localparam int RESET_W  = (dpc_pkg::WIDTH_RESET > MAX_WIDTH) ?
                             MAX_WIDTH : dpc_pkg::WIDTH_RESET;
   localparam int RESET_H  = (dpc_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                             MAX_HEIGHT : dpc_pkg::HEIGHT_RESET;

   // ------------------------------------------------------------------------
   // Configuration. Values are clamped on the way in, so the datapath only
   // ever sees legal dimensions.
   // ------------------------------------------------------------------------
   logic [WD_W-1:0] w_ff;
   logic [HT_W-1:0] h_ff;
   logic [31:0]     csr_wide;
   logic [WD_W-1:0] w_clamp;
   logic [HT_W-1:0] h_clamp;

   assign csr_ready = 1'b1;
   assign csr_wide  = 32'(csr_wdata);

   always_comb begin
      if (csr_wide < 32'(dpc_pkg::MIN_DIM)) begin
         w_clamp = WD_W'(dpc_pkg::MIN_DIM);
         h_clamp = HT_W'(dpc_pkg::MIN_DIM);
      end else begin
         w_clamp = (csr_wide > 32'(MAX_WIDTH))  ? WD_W'(MAX_WIDTH)  : WD_W'(csr_wide);
         h_clamp = (csr_wide > 32'(MAX_HEIGHT)) ? HT_W'(MAX_HEIGHT) : HT_W'(csr_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= WD_W'(RESET_W);
         h_ff <= HT_W'(RESET_H);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dpc_pkg::CSR_FRAME_WIDTH:  w_ff <= w_clamp;
            dpc_pkg::CSR_FRAME_HEIGHT: h_ff <= h_clamp;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Front end: position counters. The input position (in_col, in_rows)
   // addresses the row stores; the output position (column, row) decides
   // border and last for the result that this input releases.
   // ------------------------------------------------------------------------
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [1:0]       in_rows_ff, in_rows_in;
   logic [COL_W-1:0] column_count_ff, column_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;

   logic idle_flush;
   logic take;
   logic front_emit;
   logic front_col_end;
   logic out_col_end;
   logic out_row_end;
   logic front_border;
   logic front_last;

   logic s1_valid_ff;
   logic s1_emit_ff;
   logic s1_adv;
   logic rsp_valid_ff;

   // An item with a result needs the output register; others pass freely.
   assign s1_adv    = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;

   assign idle_flush = req_flush && (in_col_ff == '0) && (in_rows_ff == dpc_pkg::ROWS_NONE);
   assign take       = req_valid && !req_stall && !idle_flush;

   assign front_emit = (in_rows_ff == dpc_pkg::ROWS_FULL) ||
                       ((in_rows_ff == dpc_pkg::ROWS_ONE) && (in_col_ff != '0));
   assign front_col_end = ({1'b0, in_col_ff} + WD_W'(1)) >= w_ff;
   assign out_col_end   = ({1'b0, column_count_ff} + WD_W'(1)) >= w_ff;
   assign out_row_end   = ({1'b0, row_count_ff} + HT_W'(1)) >= h_ff;
   assign front_border  = (row_count_ff == '0) || out_row_end ||
                          (column_count_ff == '0) || out_col_end;
   assign front_last    = out_row_end && out_col_end;

   always_comb begin
      in_col_in       = in_col_ff;
      in_rows_in      = in_rows_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (take) begin
         if (front_emit && front_last) begin
            // Frame done: everything returns to the start of a frame.
            in_col_in       = '0;
            in_rows_in      = dpc_pkg::ROWS_NONE;
            column_count_in = '0;
            row_count_in    = '0;
         end else begin
            if (front_col_end) begin
               in_col_in = '0;
               if (in_rows_ff != dpc_pkg::ROWS_FULL) begin
                  in_rows_in = in_rows_ff + 2'd1;
               end
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
            if (front_emit) begin
               if (out_col_end) begin
                  column_count_in = '0;
                  row_count_in    = row_count_ff + ROW_W'(1);
               end else begin
                  column_count_in = column_count_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff       <= '0;
         in_rows_ff      <= dpc_pkg::ROWS_NONE;
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         in_col_ff       <= in_col_in;
         in_rows_ff      <= in_rows_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // Pack the incoming pixel: dead flag in bit 0, channels above it. A flush
   // stands in as a black, healthy pixel.
   logic [dpc_pkg::PIX_W-1:0] port_ch [dpc_pkg::PORT_CH];
   logic [dpc_pkg::PIX_W-1:0] front_ch [CHANNELS];
   logic [PIX_BITS-1:0]       front_pix;

   assign port_ch[0] = req_chan_b;
   assign port_ch[1] = req_chan_g;
   assign port_ch[2] = req_chan_r;

   for (genvar k = 0; k < CHANNELS; k++) begin : g_in_ch
      if (k < dpc_pkg::PORT_CH) begin : g_port
         assign front_ch[k] = req_flush ? '0 : port_ch[k];
      end else begin : g_none
         assign front_ch[k] = '0;
      end
   end

   always_comb begin
      front_pix[0] = req_flush ? 1'b0 : req_is_dead;
      for (int k = 0; k < CHANNELS; k++) begin
         front_pix[1 + k*dpc_pkg::PIX_W +: dpc_pkg::PIX_W] = front_ch[k];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: the item with its row store read data. The stores are read at
   // the transfer and written when the item leaves stage 1; when the item
   // leaving writes the address just read, its data is forwarded.
   // ------------------------------------------------------------------------
   logic [PIX_BITS-1:0] row_near_ff [MAX_WIDTH];
   logic [PIX_BITS-1:0] row_far_ff  [MAX_WIDTH];

   logic [PIX_BITS-1:0] near_rd_ff, far_rd_ff;
   logic [PIX_BITS-1:0] byp_near_ff, byp_far_ff;
   logic                byp_ff;
   logic                byp_hit;
   logic [PIX_BITS-1:0] near_eff, far_eff;

   logic [PIX_BITS-1:0] s1_pix_ff;
   logic [COL_W-1:0]    s1_addr_ff;
   logic                s1_border_ff;
   logic                s1_last_ff;

   assign byp_hit  = s1_adv && (s1_addr_ff == in_col_ff);
   assign near_eff = byp_ff ? byp_near_ff : near_rd_ff;
   assign far_eff  = byp_ff ? byp_far_ff  : far_rd_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         near_rd_ff <= row_near_ff[in_col_ff];
         far_rd_ff  <= row_far_ff[in_col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         row_near_ff[s1_addr_ff] <= s1_pix_ff;
         row_far_ff[s1_addr_ff]  <= near_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byp_ff       <= byp_hit;
         byp_near_ff  <= s1_pix_ff;
         byp_far_ff   <= near_eff;
         s1_pix_ff    <= front_pix;
         s1_addr_ff   <= in_col_ff;
         s1_emit_ff   <= front_emit;
         s1_border_ff <= front_border;
         s1_last_ff   <= front_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Window and correction. The new window column is the far row, the near
   // row and the current pixel; the centre and its neighbours are taken from
   // the window as it will be after this shift.
   // ------------------------------------------------------------------------
   logic [PIX_BITS-1:0] win_ff [dpc_pkg::WIN][dpc_pkg::WIN];
   logic [PIX_BITS-1:0] win_in [dpc_pkg::WIN][dpc_pkg::WIN];
   logic [PIX_BITS-1:0] centre;
   logic [dpc_pkg::PIX_W-1:0] res_ch [CHANNELS];

   always_comb begin
      for (int r = 0; r < dpc_pkg::WIN; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = far_eff;
      win_in[1][2] = near_eff;
      win_in[2][2] = s1_pix_ff;
   end

   assign centre = win_in[1][1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < dpc_pkg::WIN; r++) begin
            for (int c = 0; c < dpc_pkg::WIN; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (s1_adv) begin
         win_ff <= win_in;
      end
   end

   for (genvar k = 0; k < CHANNELS; k++) begin : g_mean
      logic [dpc_pkg::SUM_W-1:0] sum;

      always_comb begin
         sum = '0;
         for (int r = 0; r < dpc_pkg::WIN; r++) begin
            for (int c = 0; c < dpc_pkg::WIN; c++) begin
               if (r != 1 || c != 1) begin
                  sum = sum + dpc_pkg::SUM_W'(
                        win_in[r][c][1 + k*dpc_pkg::PIX_W +: dpc_pkg::PIX_W]);
               end
            end
         end
         if (!s1_border_ff && centre[0]) begin
            res_ch[k] = sum[dpc_pkg::SUM_W-1 -: dpc_pkg::PIX_W];
         end else begin
            res_ch[k] = centre[1 + k*dpc_pkg::PIX_W +: dpc_pkg::PIX_W];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Output register.
   // ------------------------------------------------------------------------
   logic [dpc_pkg::PIX_W-1:0] out_ch_ff [dpc_pkg::PORT_CH];
   logic                      out_last_ff;

   for (genvar k = 0; k < dpc_pkg::PORT_CH; k++) begin : g_out_ch
      always_ff @(posedge clock) begin
         if (s1_adv && s1_emit_ff) begin
            if (k < CHANNELS) begin
               out_ch_ff[k] <= res_ch[(k < CHANNELS) ? k : 0];
            end else begin
               out_ch_ff[k] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         out_last_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_b    = out_ch_ff[0];
   assign rsp_out_g    = out_ch_ff[1];
   assign rsp_out_r    = out_ch_ff[2];
   assign rsp_out_last = out_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // The item that releases the last result of a frame returns all position
   // counters to the start of a frame.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (take && front_emit && front_last) |=>
      (in_col_ff == '0 && in_rows_ff == dpc_pkg::ROWS_NONE &&
       column_count_ff == '0 && row_count_ff == '0))
      else $error("position counters not cleared after the last pixel");

   // The count of rows begun saturates and never passes the full mark.
   a_rows_sat: assert property (@(posedge clock) disable iff (reset)
      in_rows_ff <= dpc_pkg::ROWS_FULL)
      else $error("rows-begun counter out of range");

   // Input is held back only by a result waiting behind a stalled output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_emit_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dead pixel correction regression
// Streams whole frames of flagged pixels through the block under random
// backpressure, predicts each corrected pixel in step with every accepted
// transfer and checks the result stream field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

   // Cycles allowed for the pipeline to settle once nothing is expected.
   localparam int SETTLE_CYCLES = 8;
   // Upper bound on the run; the slowest legal run stays well inside it.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 760;
   // Rows sent of the tall frame at the end of the run.
   localparam int TALL_ROWS     = 40;
   // Percentage of cycles in which either side idles at random.
   localparam int IDLE_PCT      = 30;

   // One input transfer as the sender sees it.
   typedef struct packed {
      logic                      flush;
      logic                      is_dead;
      logic [dpc_pkg::PIX_W-1:0] chan_b;
      logic [dpc_pkg::PIX_W-1:0] chan_g;
      logic [dpc_pkg::PIX_W-1:0] chan_r;
   } pixel_item_type;

   // A raw pixel as held in the row stores and the window; ch[0] is blue,
   // ch[1] green and ch[2] red.
   typedef struct packed {
      logic                                            dead;
      logic [dpc_pkg::PORT_CH-1:0][dpc_pkg::PIX_W-1:0] ch;
   } raw_pixel_type;

   // One corrected pixel as it should leave the block.
   typedef struct packed {
      logic [dpc_pkg::PORT_CH-1:0][dpc_pkg::PIX_W-1:0] ch;
      logic                                            last;
   } corrected_type;

   logic                          clock        = 1'b0;
   logic                          reset        = 1'b1;
   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   logic                          req_flush    = 1'b0;
   logic                          req_is_dead  = 1'b0;
   logic [dpc_pkg::PIX_W-1:0]     req_chan_b   = '0;
   logic [dpc_pkg::PIX_W-1:0]     req_chan_g   = '0;
   logic [dpc_pkg::PIX_W-1:0]     req_chan_r   = '0;
   logic                          rsp_valid;
   logic                          rsp_stall    = 1'b0;
   logic [dpc_pkg::PIX_W-1:0]     rsp_out_b;
   logic [dpc_pkg::PIX_W-1:0]     rsp_out_g;
   logic [dpc_pkg::PIX_W-1:0]     rsp_out_r;
   logic                          rsp_out_last;
   logic                          csr_valid    = 1'b0;
   logic                          csr_ready;
   logic [dpc_pkg::CSR_IDX_W-1:0] csr_index    = dpc_pkg::CSR_FRAME_WIDTH;
   logic [dpc_pkg::DIM_CFG_W-1:0] csr_wdata    = '0;

   dead_pixel_correction i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_flush    (req_flush),
      .req_is_dead  (req_is_dead),
      .req_chan_b   (req_chan_b),
      .req_chan_g   (req_chan_g),
      .req_chan_r   (req_chan_r),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_b    (rsp_out_b),
      .rsp_out_g    (rsp_out_g),
      .rsp_out_r    (rsp_out_r),
      .rsp_out_last (rsp_out_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Shared testbench state
   // -------------------------------------------------------------------------
   // Pixels waiting to be offered, filled by the stimulus sequence and
   // drained by the sender.
   pixel_item_type pending_pixels[$];
   // Corrected pixels predicted but not yet seen on the result channel.
   corrected_type  corrected_due[$];

   int unsigned faults          = 0;
   int unsigned cycles_run      = 0;
   int unsigned pixels_accepted = 0;
   int unsigned results_seen    = 0;

   // Receiver hold-off: a single long stretch of stall, counted down here.
   int unsigned hold_left       = 0;
   logic        hold_done       = 1'b0;

   pixel_item_type next_pixel;
   corrected_type  seen_due;

   // -------------------------------------------------------------------------
   // Prediction state: our own copy of the registers, the row stores, the
   // window and the position counters.
   // -------------------------------------------------------------------------
   logic [dpc_pkg::DIM_CFG_W-1:0] width_reg;
   logic [dpc_pkg::DIM_CFG_W-1:0] height_reg;
   raw_pixel_type                 line_near[dpc_pkg::MAX_WIDTH_DEF];
   raw_pixel_type                 line_far[dpc_pkg::MAX_WIDTH_DEF];
   raw_pixel_type                 window_px[dpc_pkg::WIN][dpc_pkg::WIN];
   int unsigned                   out_col;
   int unsigned                   out_row;
   int unsigned                   in_col;
   int unsigned                   rows_begun;

   // The block clamps both dimensions into the legal range; the prediction
   // keeps the raw value and clamps it wherever it is used.
   function automatic int unsigned usable_dim(input logic [dpc_pkg::DIM_CFG_W-1:0] raw,
                                              input int unsigned top);
      if (raw < dpc_pkg::MIN_DIM) return dpc_pkg::MIN_DIM;
      if (raw > top) return top;
      return 32'(raw);
   endfunction

   task automatic clear_prediction();
      width_reg  = dpc_pkg::DIM_CFG_W'(dpc_pkg::WIDTH_RESET);
      height_reg = dpc_pkg::DIM_CFG_W'(dpc_pkg::HEIGHT_RESET);
      for (int i = 0; i < dpc_pkg::MAX_WIDTH_DEF; i++) begin
         line_near[i] = '0;
         line_far[i]  = '0;
      end
      for (int r = 0; r < dpc_pkg::WIN; r++) begin
         for (int c = 0; c < dpc_pkg::WIN; c++) begin
            window_px[r][c] = '0;
         end
      end
      out_col    = 0;
      out_row    = 0;
      in_col     = 0;
      rows_begun = 0;
   endtask

   // Advances the window by one accepted input transfer and, once the frame
   // has primed, queues the corrected pixel at the window centre.
   task automatic predict_correction(input pixel_item_type item);
      int unsigned   cols;
      int unsigned   rows;
      int unsigned   addr;
      int unsigned   total;
      logic          produce;
      logic          on_border;
      logic          closing;
      raw_pixel_type fresh;
      corrected_type due;

      cols = usable_dim(width_reg, dpc_pkg::MAX_WIDTH_DEF);
      rows = usable_dim(height_reg, dpc_pkg::MAX_HEIGHT_DEF);

      // A flush before any pixel of a frame is taken and dropped.
      if (item.flush && in_col == 0 && rows_begun == 0) return;

      // A flush inside a frame stands for a black, healthy pixel.
      fresh = '0;
      if (!item.flush) begin
         fresh.dead = item.is_dead;
         fresh.ch   = {item.chan_r, item.chan_g, item.chan_b};
      end

      // The first row and one pixel of a frame only prime the window.
      produce = rows_begun >= 2 || (rows_begun == 1 && in_col >= 1);

      addr = (in_col < dpc_pkg::MAX_WIDTH_DEF) ? in_col : 0;
      for (int r = 0; r < dpc_pkg::WIN; r++) begin
         window_px[r][0] = window_px[r][1];
         window_px[r][1] = window_px[r][2];
      end
      window_px[0][2] = line_far[addr];
      window_px[1][2] = line_near[addr];
      window_px[2][2] = fresh;
      line_far[addr]  = line_near[addr];
      line_near[addr] = fresh;

      if (in_col + 1 >= cols) begin
         in_col = 0;
         if (rows_begun < 2) rows_begun++;
      end else begin
         in_col++;
      end

      if (!produce) return;

      on_border = out_row == 0 || out_row + 1 >= rows ||
                  out_col == 0 || out_col + 1 >= cols;
      closing   = out_row + 1 >= rows && out_col + 1 >= cols;

      for (int k = 0; k < dpc_pkg::PORT_CH; k++) begin
         due.ch[k] = window_px[1][1].ch[k];
         if (!on_border && window_px[1][1].dead) begin
            total = 0;
            for (int r = 0; r < dpc_pkg::WIN; r++) begin
               for (int c = 0; c < dpc_pkg::WIN; c++) begin
                  if (r != 1 || c != 1) total += window_px[r][c].ch[k];
               end
            end
            due.ch[k] = dpc_pkg::PIX_W'(total >> dpc_pkg::MEAN_SHIFT);
         end
      end
      due.last = closing;
      corrected_due = {corrected_due, due};

      // After the marked pixel every counter starts the next frame afresh.
      if (closing) begin
         out_col    = 0;
         out_row    = 0;
         in_col     = 0;
         rows_begun = 0;
      end else if (out_col + 1 >= cols) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endtask

   // -------------------------------------------------------------------------
   // Clock, reset and the run limit
   // -------------------------------------------------------------------------
   initial begin
      forever #6 clock = ~clock;
   end

   // Reset is held at the start and never asserted again.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // A hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run >= CYCLE_LIMIT) begin
         $display("dead_pixel_correction regression: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sender: offers the queued pixels, idling at random. A payload that is
   // stalled stays on the port until its transfer completes. Every completed
   // transfer is handed to the prediction at the edge where it happens.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_correction({req_flush, req_is_dead, req_chan_b, req_chan_g,
                                req_chan_r});
            pixels_accepted++;
         end
         // A new item may be placed only once the port is free. Between
         // three and seven hundred transfers the sender never idles.
         if (!req_valid || !req_stall) begin
            if (pending_pixels.size() != 0 &&
                ((pixels_accepted >= 300 && pixels_accepted < 700) ||
                 $urandom_range(0, 99) >= IDLE_PCT)) begin
               next_pixel = pending_pixels.pop_front();
               req_valid   <= 1'b1;
               req_flush   <= next_pixel.flush;
               req_is_dead <= next_pixel.is_dead;
               req_chan_b  <= next_pixel.chan_b;
               req_chan_g  <= next_pixel.chan_g;
               req_chan_r  <= next_pixel.chan_r;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: checks each result transfer against the oldest prediction and
   // drives the stall. After two hundred results it holds off once, so that
   // the block fills and stalls its input; between four and eight hundred
   // results it never stalls.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (corrected_due.size() == 0) begin
               $error("result transfer with no pixel due: b=%0d g=%0d r=%0d last=%0d",
                      rsp_out_b, rsp_out_g, rsp_out_r, rsp_out_last);
               faults++;
            end else begin
               seen_due = corrected_due.pop_front();
               if (rsp_out_b !== seen_due.ch[0]) begin
                  $error("out_b expected %0d actual %0d", seen_due.ch[0], rsp_out_b);
                  faults++;
               end
               if (rsp_out_g !== seen_due.ch[1]) begin
                  $error("out_g expected %0d actual %0d", seen_due.ch[1], rsp_out_g);
                  faults++;
               end
               if (rsp_out_r !== seen_due.ch[2]) begin
                  $error("out_r expected %0d actual %0d", seen_due.ch[2], rsp_out_r);
                  faults++;
               end
               if (rsp_out_last !== seen_due.last) begin
                  $error("out_last expected %0d actual %0d", seen_due.last,
                         rsp_out_last);
                  faults++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && results_seen >= 200) begin
            hold_done = 1'b1;
            hold_left = 300;
            rsp_stall <= 1'b1;
         end else if (results_seen >= 400 && results_seen < 800) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus sequence
   // -------------------------------------------------------------------------
   task automatic queue_item(input logic flush, input logic is_dead,
                             input logic [dpc_pkg::PIX_W-1:0] b,
                             input logic [dpc_pkg::PIX_W-1:0] g,
                             input logic [dpc_pkg::PIX_W-1:0] r);
      pending_pixels = {pending_pixels, pixel_item_type'({flush, is_dead, b, g, r})};
   endtask

   // Channel values in one of three flavours: anything, the two extremes
   // only, or a narrow band at the top, which stresses the neighbour sum.
   function automatic logic [dpc_pkg::PIX_W-1:0] pick_level(input int unsigned style);
      case (style)
         0: begin
            return dpc_pkg::PIX_W'($urandom_range(0, 255));
         end
         1: begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: begin
            return dpc_pkg::PIX_W'($urandom_range(224, 255));
         end
      endcase
   endfunction

   // Queues one whole frame followed by the width+1 tail positions that push
   // its last pixels out. Most tail positions are flushes; the rest are
   // pixels, which the block absorbs as tail. A few pixels inside the frame
   // are replaced by flushes, never the first, which would be dropped.
   // Stray flushes before and after the frame are dropped by the block and
   // are not counted.
   task automatic queue_frame(input int unsigned cols, input int unsigned rows,
                              input int unsigned dead_pct, input int unsigned style,
                              input int unsigned gap_pct, output int unsigned count);
      pixel_item_type item;
      int unsigned    p;
      count = 0;
      if ($urandom_range(0, 3) == 0) begin
         queue_item(1'b1, 1'($urandom_range(0, 1)), pick_level(0), pick_level(0),
                    pick_level(0));
      end
      for (p = 0; p < cols * rows + cols + 1; p++) begin
         item.flush   = 1'b0;
         item.is_dead = $urandom_range(0, 99) < dead_pct;
         item.chan_b  = pick_level(style);
         item.chan_g  = pick_level(style);
         item.chan_r  = pick_level(style);
         if (p >= cols * rows) begin
            item.flush = $urandom_range(0, 99) >= 20;
         end else if (p != 0 && $urandom_range(0, 99) < gap_pct) begin
            item.flush = 1'b1;
         end
         pending_pixels = {pending_pixels, item};
         count++;
      end
      if ($urandom_range(0, 3) == 0) begin
         queue_item(1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
      end
   endtask

   // Writes both dimension registers back to back; valid stays high across
   // the two transfers. Called only while the block is idle.
   task automatic set_frame_size(input logic [dpc_pkg::DIM_CFG_W-1:0] cols_raw,
                                 input logic [dpc_pkg::DIM_CFG_W-1:0] rows_raw);
      csr_valid <= 1'b1;
      csr_index <= dpc_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= cols_raw;
      do @(posedge clock); while (!csr_ready);
      width_reg = cols_raw;
      csr_index <= dpc_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= rows_raw;
      do @(posedge clock); while (!csr_ready);
      height_reg = rows_raw;
      csr_valid <= 1'b0;
   endtask

   // The stimulus stops here until every predicted pixel has come back, then
   // lets the pipeline settle before anything else is changed.
   task automatic drain();
      while (pending_pixels.size() != 0 || req_valid || corrected_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned                   random_items;
      int unsigned                   added;
      int unsigned                   dead_pct;
      logic [dpc_pkg::DIM_CFG_W-1:0] cols_raw;
      logic [dpc_pkg::DIM_CFG_W-1:0] rows_raw;

      clear_prediction();
      random_items = 0;
      while (reset) @(posedge clock);

      // Directed part. Both registers are written below the legal minimum,
      // so the frames are three by three and only the centre is interior.
      set_frame_size(dpc_pkg::DIM_CFG_W'(0), dpc_pkg::DIM_CFG_W'(2));
      // A flush with no frame begun is dropped.
      queue_item(1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF);
      // Blue neighbours all full scale, green all zero, red varied. The dead
      // centre takes their mean; the dead corners lie on the border and pass.
      for (int p = 0; p < 9; p++) begin
         queue_item(1'b0, p == 0 || p == 4 || p == 8,
                    (p == 4) ? 8'd77 : 8'hFF,
                    (p == 4) ? 8'd77 : 8'h00,
                    (p == 4) ? 8'd77 : dpc_pkg::PIX_W'(p * 30 + 5));
      end
      // Tail of the frame: a pixel in a tail position is only absorbed.
      queue_item(1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
      queue_item(1'b0, 1'b1, 8'h12, 8'h34, 8'h56);
      queue_item(1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
      queue_item(1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
      queue_item(1'b1, 1'b1, 8'hAA, 8'h55, 8'hFF);
      // Second frame: a flush in the top middle stands for a black neighbour,
      // so the dead centre gets seven full-scale neighbours and one zero.
      for (int p = 0; p < 9; p++) begin
         queue_item(p == 1, p == 4 || p == 7, 8'hFF, 8'hFF, 8'hFF);
      end
      repeat (4) queue_item(1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
      drain();

      // Random part: mostly small frames with random content, now and then
      // a dimension written below the minimum.
      while (random_items < RANDOM_ITEMS) begin
         cols_raw = ($urandom_range(0, 9) == 0) ?
                    dpc_pkg::DIM_CFG_W'($urandom_range(0, 2)) :
                    dpc_pkg::DIM_CFG_W'($urandom_range(3, 12));
         rows_raw = ($urandom_range(0, 9) == 0) ?
                    dpc_pkg::DIM_CFG_W'($urandom_range(0, 2)) :
                    dpc_pkg::DIM_CFG_W'($urandom_range(3, 8));
         set_frame_size(cols_raw, rows_raw);
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
               0:       dead_pct = 0;
               1:       dead_pct = 15;
               2:       dead_pct = 50;
               default: dead_pct = 100;
            endcase
            queue_frame(usable_dim(cols_raw, dpc_pkg::MAX_WIDTH_DEF),
                        usable_dim(rows_raw, dpc_pkg::MAX_HEIGHT_DEF), dead_pct,
                        $urandom_range(0, 2), $urandom_range(0, 1) ? 5 : 0, added);
            random_items += added;
         end
         drain();
      end

      // A tall frame, three pixels wide: the height register with every bit
      // set clamps to the full row count. Only its first rows are sent, so
      // none of the results may be taken for the bottom border or the last.
      set_frame_size(dpc_pkg::DIM_CFG_W'(3), dpc_pkg::DIM_CFG_W'(2047));
      for (int p = 0; p < TALL_ROWS * dpc_pkg::MIN_DIM; p++) begin
         queue_item(1'b0, $urandom_range(0, 99) < 30, pick_level(0), pick_level(0),
                    pick_level(0));
      end
      drain();

      if (corrected_due.size() != 0) begin
         $error("%0d corrected pixels never arrived", corrected_due.size());
         faults++;
      end
      if (faults == 0) begin
         $display("dead_pixel_correction regression: pass");
      end else begin
         $display("dead_pixel_correction regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/dpc_pkg.sv
hw/rtl/dead_pixel_correction.sv
dv/testbench.sv
